// ===== design/teq_pkg.sv =====
package teq_pkg;

   // Field widths
   localparam int unsigned ID_W      = 32;
   localparam int unsigned DELAY_W   = 31;
   localparam int unsigned ELAPSED_W = 16;
   localparam int unsigned TIME_W    = 48;
   localparam int unsigned SUM_W     = TIME_W + 1;
   localparam int unsigned COUNT_W   = 5;
   localparam int unsigned MS_W      = 41;

   // Beat widths, padded to whole bytes
   localparam int unsigned REQ_DATA_W = 80;
   localparam int unsigned RSP_DATA_W = 88;

   // Fixed behaviour
   localparam int unsigned MS_PER_SEC = 1000;
   localparam int unsigned RESULT_CAP = 16;
   localparam int unsigned FIRE_W     = 5;
   localparam int unsigned COUNT_MAX  = 31;

   typedef enum logic [1:0] {
      FUNC_SET_MS  = 2'd0,
      FUNC_SET_SEC = 2'd1,
      FUNC_KILL    = 2'd2,
      FUNC_TICK    = 2'd3
   } func_type;

   typedef enum logic [1:0] {
      KIND_SET_OK    = 2'd0,
      KIND_SET_FULL  = 2'd1,
      KIND_KILL_DONE = 2'd2,
      KIND_FIRED     = 2'd3
   } kind_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SET_MUL,
      ST_SET_ADD,
      ST_SET_OUT,
      ST_SCAN,
      ST_SCAN_END,
      ST_KILL_OUT,
      ST_TICK_PICK,
      ST_TICK_FLUSH
   } state_type;

   typedef struct packed {
      logic [ID_W-1:0]   id;
      logic [TIME_W-1:0] expiry;
   } entry_type;

endpackage

// ===== design/timer_expiry_queue.sv =====
// Set request: the delay is scaled in ST_SET_MUL, the expiry added in ST_SET_ADD and the result
//   registered from ST_SET_OUT; one request at a time. Kill request: one pass over the slot memory.
// Tick: one pass over the slot memory when nothing fires; each fired timer costs one more full
//   pass, set by the single read port of the slot memory.
// Reset (synchronous, active high) clears the clock, all slot valid bits and the
//   result valid flag; slot contents are left as they are and read only when valid.
module timer_expiry_queue #(
   parameter int unsigned TIMER_SLOTS = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // timer_id [31:0], delay [62:32], elapsed_ms [78:63], zero [79]
   input  logic [teq_pkg::REQ_DATA_W-1:0]      req_tdata,
   // func [1:0]
   input  logic [1:0]                          req_tuser,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // fired_id [31:0], expiry_time [79:32], removed_count [84:80], zero [87:85]
   output logic [teq_pkg::RSP_DATA_W-1:0]      rsp_tdata,
   // kind [1:0]
   output logic [1:0]                          rsp_tuser,
   output logic                                rsp_tlast
);

   localparam int unsigned IDX_W = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;
   localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(TIMER_SLOTS - 1);

   // Request fields
   logic [teq_pkg::ID_W-1:0]      req_id;
   logic [teq_pkg::DELAY_W-1:0]   req_delay;
   logic [teq_pkg::ELAPSED_W-1:0] req_elapsed;
   teq_pkg::func_type             req_func;

   // Control
   teq_pkg::state_type state_ff, state_in;
   logic               req_fire;
   logic               out_free;
   logic               out_load;
   logic               scan_start;
   logic               scan_read;
   logic               take_best;
   logic               set_write;

   // Request hold and arithmetic
   teq_pkg::func_type             func_ff;
   logic [teq_pkg::ID_W-1:0]      id_ff;
   logic [teq_pkg::DELAY_W-1:0]   delay_ff;
   logic [teq_pkg::TIME_W-1:0]    clock_ff;
   logic [teq_pkg::MS_W-1:0]      ms_ff, ms_in;
   logic [teq_pkg::TIME_W-1:0]    exp_ff, exp_in;
   logic [teq_pkg::SUM_W-1:0]     set_sum, tick_sum;
   logic [teq_pkg::TIME_W-1:0]    clock_in;

   // Slot storage
   logic [TIMER_SLOTS-1:0] valid_ff;
   teq_pkg::entry_type     mem [TIMER_SLOTS];
   teq_pkg::entry_type     rd_ff;
   logic                   free_found, free_found_ff;
   logic [IDX_W-1:0]       free_idx, free_idx_ff;

   // Scan
   logic [IDX_W-1:0]             scan_idx_ff;
   logic                         cmp_en_ff;
   logic [IDX_W-1:0]             cmp_idx_ff;
   logic                         kill_hit;
   logic                         tick_hit;
   logic [teq_pkg::COUNT_W-1:0]  kill_cnt_ff;
   logic                         best_found_ff;
   logic [IDX_W-1:0]             best_idx_ff;
   teq_pkg::entry_type           best_ff;
   logic                         pend_ff;
   teq_pkg::entry_type           pend_entry_ff;
   logic [teq_pkg::FIRE_W-1:0]   fire_cnt_ff;

   // Result register
   logic                         rsp_tvalid_ff;
   teq_pkg::kind_type            rsp_kind_ff, out_kind;
   logic [teq_pkg::ID_W-1:0]     rsp_id_ff, out_id;
   logic [teq_pkg::TIME_W-1:0]   rsp_exp_ff, out_exp;
   logic [teq_pkg::COUNT_W-1:0]  rsp_cnt_ff, out_cnt;
   logic                         rsp_last_ff, out_last;

   // Unpack the request beat
   assign req_id      = req_tdata[31:0];
   assign req_delay   = req_tdata[62:32];
   assign req_elapsed = req_tdata[78:63];
   assign req_func    = teq_pkg::func_type'(req_tuser);
   assign req_fire    = req_tvalid && req_tready;
   assign out_free    = !rsp_tvalid_ff || rsp_tready;

   // Saturating clock advance for a tick
   assign tick_sum = {1'b0, clock_ff} + teq_pkg::SUM_W'(req_elapsed);
   assign clock_in = tick_sum[teq_pkg::TIME_W] ? '1 : tick_sum[teq_pkg::TIME_W-1:0];

   // Delay in milliseconds, then saturating expiry
   assign ms_in = (func_ff == teq_pkg::FUNC_SET_SEC) ?
                  teq_pkg::MS_W'(delay_ff) * teq_pkg::MS_W'(teq_pkg::MS_PER_SEC) :
                  teq_pkg::MS_W'(delay_ff);
   assign set_sum = {1'b0, clock_ff} + teq_pkg::SUM_W'(ms_ff);
   assign exp_in  = set_sum[teq_pkg::TIME_W] ? '1 : set_sum[teq_pkg::TIME_W-1:0];

   // Lowest free slot
   always_comb begin
      free_found = 1'b0;
      free_idx   = '0;
      for (int i = TIMER_SLOTS - 1; i >= 0; i--) begin
         if (!valid_ff[i]) begin
            free_found = 1'b1;
            free_idx   = IDX_W'(i);
         end
      end
   end

   // Compare the entry read in the previous cycle
   assign kill_hit = cmp_en_ff && valid_ff[cmp_idx_ff] && (rd_ff.id == id_ff);
   assign tick_hit = cmp_en_ff && valid_ff[cmp_idx_ff] && (rd_ff.expiry <= clock_ff) &&
                     (!best_found_ff || (rd_ff.expiry < best_ff.expiry));

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= teq_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state and strobes
   always_comb begin
      state_in   = state_ff;
      req_tready = 1'b0;
      out_load   = 1'b0;
      out_kind   = teq_pkg::KIND_SET_OK;
      out_id     = id_ff;
      out_exp    = '0;
      out_cnt    = '0;
      out_last   = 1'b1;
      scan_start = 1'b0;
      scan_read  = 1'b0;
      take_best  = 1'b0;
      set_write  = 1'b0;
      case (state_ff)
         teq_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               case (req_func)
                  teq_pkg::FUNC_SET_MS, teq_pkg::FUNC_SET_SEC: state_in = teq_pkg::ST_SET_MUL;
                  teq_pkg::FUNC_KILL, teq_pkg::FUNC_TICK: begin
                     scan_start = 1'b1;
                     state_in   = teq_pkg::ST_SCAN;
                  end
                  default: state_in = teq_pkg::ST_IDLE;
               endcase
            end
         end
         teq_pkg::ST_SET_MUL: state_in = teq_pkg::ST_SET_ADD;
         teq_pkg::ST_SET_ADD: state_in = teq_pkg::ST_SET_OUT;
         teq_pkg::ST_SET_OUT: begin
            if (out_free) begin
               out_load = 1'b1;
               if (free_found_ff) begin
                  set_write = 1'b1;
                  out_kind  = teq_pkg::KIND_SET_OK;
                  out_exp   = exp_ff;
               end else begin
                  out_kind  = teq_pkg::KIND_SET_FULL;
               end
               state_in = teq_pkg::ST_IDLE;
            end
         end
         teq_pkg::ST_SCAN: begin
            scan_read = 1'b1;
            if (scan_idx_ff == IDX_LAST) begin
               state_in = teq_pkg::ST_SCAN_END;
            end
         end
         teq_pkg::ST_SCAN_END: begin
            state_in = (func_ff == teq_pkg::FUNC_KILL) ? teq_pkg::ST_KILL_OUT :
                                                         teq_pkg::ST_TICK_PICK;
         end
         teq_pkg::ST_KILL_OUT: begin
            if (out_free) begin
               out_load = 1'b1;
               out_kind = teq_pkg::KIND_KILL_DONE;
               out_cnt  = kill_cnt_ff;
               state_in = teq_pkg::ST_IDLE;
            end
         end
         teq_pkg::ST_TICK_PICK: begin
            if (!pend_ff || out_free) begin
               // Release the held timer; it is the last one if this pass found none
               if (pend_ff) begin
                  out_load = 1'b1;
                  out_kind = teq_pkg::KIND_FIRED;
                  out_id   = pend_entry_ff.id;
                  out_exp  = pend_entry_ff.expiry;
                  out_last = !best_found_ff;
               end
               if (best_found_ff) begin
                  take_best = 1'b1;
                  if (fire_cnt_ff == teq_pkg::FIRE_W'(teq_pkg::RESULT_CAP - 1)) begin
                     state_in = teq_pkg::ST_TICK_FLUSH;
                  end else begin
                     scan_start = 1'b1;
                     state_in   = teq_pkg::ST_SCAN;
                  end
               end else begin
                  state_in = teq_pkg::ST_IDLE;
               end
            end
         end
         teq_pkg::ST_TICK_FLUSH: begin
            if (out_free) begin
               out_load = 1'b1;
               out_kind = teq_pkg::KIND_FIRED;
               out_id   = pend_entry_ff.id;
               out_exp  = pend_entry_ff.expiry;
               state_in = teq_pkg::ST_IDLE;
            end
         end
         default: state_in = teq_pkg::ST_IDLE;
      endcase
   end

   // Clock and slot valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         clock_ff  <= '0;
         valid_ff  <= '0;
         cmp_en_ff <= 1'b0;
         pend_ff   <= 1'b0;
      end else begin
         cmp_en_ff <= scan_read;
         if (req_fire && (req_func == teq_pkg::FUNC_TICK)) begin
            clock_ff <= clock_in;
         end
         if (req_fire) begin
            pend_ff <= 1'b0;
         end else if (take_best) begin
            pend_ff <= 1'b1;
         end
         if (set_write) begin
            valid_ff[free_idx_ff] <= 1'b1;
         end
         if ((func_ff == teq_pkg::FUNC_KILL) && kill_hit) begin
            valid_ff[cmp_idx_ff] <= 1'b0;
         end
         if (take_best) begin
            valid_ff[best_idx_ff] <= 1'b0;
         end
      end
   end

   // Slot memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (set_write) begin
         mem[free_idx_ff] <= '{id: id_ff, expiry: exp_ff};
      end
      if (scan_read) begin
         rd_ff <= mem[scan_idx_ff];
      end
   end

   // Request hold, set arithmetic and scan datapath
   always_ff @(posedge clock) begin
      if (req_fire) begin
         func_ff       <= req_func;
         id_ff         <= req_id;
         delay_ff      <= req_delay;
         free_found_ff <= free_found;
         free_idx_ff   <= free_idx;
         fire_cnt_ff   <= '0;
      end
      if (state_ff == teq_pkg::ST_SET_MUL) begin
         ms_ff <= ms_in;
      end
      if (state_ff == teq_pkg::ST_SET_ADD) begin
         exp_ff <= exp_in;
      end
      if (scan_start) begin
         scan_idx_ff   <= '0;
         best_found_ff <= 1'b0;
         kill_cnt_ff   <= '0;
      end else if (scan_read) begin
         scan_idx_ff <= scan_idx_ff + 1'b1;
      end
      if (scan_read) begin
         cmp_idx_ff <= scan_idx_ff;
      end
      // Count kills, saturating
      if ((func_ff == teq_pkg::FUNC_KILL) && kill_hit &&
          (kill_cnt_ff != teq_pkg::COUNT_W'(teq_pkg::COUNT_MAX))) begin
         kill_cnt_ff <= kill_cnt_ff + 1'b1;
      end
      // Track the earliest due entry, lowest slot on a tie
      if ((func_ff == teq_pkg::FUNC_TICK) && tick_hit && !scan_start) begin
         best_found_ff <= 1'b1;
         best_idx_ff   <= cmp_idx_ff;
         best_ff       <= rd_ff;
      end
      if (take_best) begin
         pend_entry_ff <= best_ff;
         fire_cnt_ff   <= fire_cnt_ff + 1'b1;
      end
   end

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_tvalid_ff <= 1'b0;
      end else if (out_load) begin
         rsp_tvalid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_tvalid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_kind_ff <= out_kind;
         rsp_id_ff   <= out_id;
         rsp_exp_ff  <= out_exp;
         rsp_cnt_ff  <= out_cnt;
         rsp_last_ff <= out_last;
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = {3'b000, rsp_cnt_ff, rsp_exp_ff, rsp_id_ff};
   assign rsp_tuser  = rsp_kind_ff;
   assign rsp_tlast  = rsp_last_ff;

`ifndef NO_ASSERTIONS
   // Compare slots only follow reads issued by a scan
   a_cmp_in_scan: assert property (@(posedge clock) disable iff (reset)
      cmp_en_ff |-> (state_ff == teq_pkg::ST_SCAN || state_ff == teq_pkg::ST_SCAN_END))
      else $error("slot compare outside a scan");

   // A fired timer is never later than the clock
   a_fired_due: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid_ff && (rsp_kind_ff == teq_pkg::KIND_FIRED)) |-> (rsp_exp_ff <= clock_ff))
      else $error("fired timer not yet due");

   // A stored timer occupies its slot afterwards
   a_set_marks_valid: assert property (@(posedge clock) disable iff (reset)
      set_write |=> valid_ff[free_idx_ff])
      else $error("stored slot not marked valid");

   // Only a live, chosen entry is released
   a_take_live: assert property (@(posedge clock) disable iff (reset)
      take_best |-> (best_found_ff && valid_ff[best_idx_ff]))
      else $error("released slot not valid");
`endif

endmodule
